FILE: rtl/tmh_pkg.sv
// Shared types, constants and the deadline distance function of the timer heap.
package tmh_pkg;

  localparam int IdW = 6;
  localparam int DlW = 32;
  localparam int IdCount = 1 << IdW;
  localparam logic [DlW-1:0] OverdueLimit = 32'h7FFF_FFFF;

  // Command codes carried in the action field.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NOP    = 2'd3
  } tmh_action_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NOT_DUE   = 2'd3
  } tmh_status_t;

  // One heap slot: timer id and absolute deadline.
  typedef struct packed {
    logic [IdW-1:0] id;
    logic [DlW-1:0] dl;
  } tmh_entry_t;

  // Per-id repeat settings.
  typedef struct packed {
    logic           rep;
    logic [DlW-1:0] period;
  } tmh_period_t;

  // Distance of a deadline from the current time; anything past the half range is overdue.
  function automatic logic [DlW-1:0] dist_of(input logic [DlW-1:0] dl,
                                             input logic [DlW-1:0] now);
    logic [DlW-1:0] d;
    d = dl - now;
    return (d > OverdueLimit) ? '0 : d;
  endfunction

endpackage

FILE: rtl/tmh_cmd_if.sv
// Command channel of the timer heap: valid, ready and one command word.
interface tmh_cmd_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [tmh_pkg::IdW-1:0]  timer_id;
  logic [tmh_pkg::DlW-1:0]  deadline;
  logic [tmh_pkg::DlW-1:0]  interval;
  logic                     repeating;
  logic [tmh_pkg::DlW-1:0]  now;

  modport source (output valid, action, timer_id, deadline, interval, repeating, now,
                  input ready);
  modport sink (input valid, action, timer_id, deadline, interval, repeating, now,
                output ready);
endinterface

FILE: rtl/tmh_res_if.sv
// Result channel of the timer heap: valid, ready and one result word.
interface tmh_res_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic                     fired;
  logic [tmh_pkg::IdW-1:0]  fired_id;
  logic [5:0]               timer_count;
  logic [tmh_pkg::DlW-1:0]  next_deadline;

  modport source (output valid, status, fired, fired_id, timer_count, next_deadline,
                  input ready);
  modport sink (input valid, status, fired, fired_id, timer_count, next_deadline,
                output ready);
endinterface

FILE: rtl/timer_min_heap_scheduler.sv
// Timer queue kept as a binary min-heap in block memory, run by a small sequencer.
//
//   channel | dir | word
//   --------+-----+-------------------------------------------------------------
//   cmd     | in  | action, timer_id, deadline, interval, repeating, now
//   res     | out | status, fired, fired_id, timer_count, next_deadline
//
// One command word at a time; cmd.ready is high only while the sequencer is idle, and
// the cycle in which a word is taken is an idle cycle. A no-op goes straight to the
// result; an insert sifts the new entry up, or reports full; a tick reports not due on an
// empty heap or when the root is not due, else fires the root and sifts the rescheduled
// root, or the last entry after a one-shot, down; a delete scans linearly for the id (not
// found on a miss), moves the last entry into the hole unless the hole was the last slot,
// then sifts up and, when the entry did not climb, sifts down.
// The sequencer's pace is set by the single distance compare unit and the registered
// heap memory read. Reset clears the count; no clearing pass over the memories.
// A waiting result does not block the next command; a new result waits for the old.
module timer_min_heap_scheduler #(
  parameter int MAX_TIMERS = 63
) (
  input  logic       clk,
  input  logic       rst,
  tmh_cmd_if.sink    cmd,
  tmh_res_if.source  res
);

  localparam int IW = $clog2(MAX_TIMERS + 1);
  localparam int HeapDepth = 1 << IW;

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_SRCH, S_DEL_RD, S_DEL_MV, S_TK_RD, S_TK_CHK, S_TK_APPLY,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP_L, S_DN_CMP_R, S_FIN
  } state_t;

  typedef enum logic [1:0] {SEL_SELF, SEL_LEFT, SEL_RIGHT} sel_t;

  state_t                       state;
  logic [IW-1:0]                count;
  logic [IW-1:0]                n;
  tmh_pkg::tmh_entry_t          cur;
  logic [tmh_pkg::DlW-1:0]      best_dl;
  sel_t                         best_sel;
  logic                         moved;
  logic                         del_mode;
  logic [IW:0]                  scan;
  logic [IW-1:0]                chk_pos;
  logic                         chk_vld;
  logic [IW-1:0]                hit;
  logic [tmh_pkg::IdW-1:0]      id_q;
  logic [tmh_pkg::DlW-1:0]      dl_q;
  logic [tmh_pkg::DlW-1:0]      iv_q;
  logic                         rep_q;
  logic [tmh_pkg::DlW-1:0]      now_q;
  tmh_pkg::tmh_status_t         st_q;
  logic                         fired_q;
  logic [tmh_pkg::IdW-1:0]      fid_q;
  logic [tmh_pkg::DlW-1:0]      root_dl;

  logic                         out_valid;
  tmh_pkg::tmh_status_t         out_status;
  logic                         out_fired;
  logic [tmh_pkg::IdW-1:0]      out_fid;
  logic [5:0]                   out_count;
  logic [tmh_pkg::DlW-1:0]      out_next;
  logic                         fin_take;

  // Heap memory with one write port and two registered read ports.
  tmh_pkg::tmh_entry_t          heap_mem [HeapDepth];
  tmh_pkg::tmh_entry_t          rd_a;
  tmh_pkg::tmh_entry_t          rd_b;
  logic [IW-1:0]                addr_a;
  logic [IW-1:0]                addr_b;
  logic                         we;
  logic [IW-1:0]                waddr;
  tmh_pkg::tmh_entry_t          wdata;

  // Per-id repeat memory.
  tmh_pkg::tmh_period_t         per_mem [tmh_pkg::IdCount];
  tmh_pkg::tmh_period_t         per_rd;
  logic                         per_we;

  logic [IW:0]                  child_l;
  logic [IW:0]                  child_r;
  logic [IW:0]                  count_x;
  logic [IW-1:0]                parent;
  logic                         l_ok;
  logic                         r_ok;
  logic [tmh_pkg::DlW-1:0]      cmp_a;
  logic [tmh_pkg::DlW-1:0]      cmp_b;
  logic [tmh_pkg::DlW-1:0]      dist_a;
  logic [tmh_pkg::DlW-1:0]      dist_b;
  logic                         lt;
  logic                         due;
  logic                         up_finish;
  logic                         up_write_cur;
  sel_t                         dn_sel;
  logic [IW+5:0]                count_ext;

  // Heap neighbors of the current position.
  assign child_l = {n, 1'b0};
  assign child_r = {n, 1'b1};
  assign count_x = {1'b0, count};
  assign parent  = {1'b0, n[IW-1:1]};
  assign l_ok    = (child_l <= count_x);
  assign r_ok    = (child_r <= count_x);

  // The shared distance compare unit and its operand selection.
  always_comb begin
    cmp_a = cur.dl;
    cmp_b = best_dl;
    case (state)
      S_UP_CMP: begin
        cmp_a = cur.dl;
        cmp_b = rd_a.dl;
      end
      S_DN_CMP_L: begin
        cmp_a = rd_a.dl;
        cmp_b = cur.dl;
      end
      S_DN_CMP_R: begin
        cmp_a = rd_b.dl;
        cmp_b = best_dl;
      end
      S_TK_CHK: begin
        cmp_a = rd_a.dl;
        cmp_b = best_dl;
      end
      default: begin
        cmp_a = cur.dl;
        cmp_b = best_dl;
      end
    endcase
  end

  assign dist_a = tmh_pkg::dist_of(cmp_a, now_q);
  assign dist_b = tmh_pkg::dist_of(cmp_b, now_q);
  assign lt     = (dist_a < dist_b);
  assign due    = (dist_a == '0);

  // Sift-up ends at the root or when the parent is not farther away.
  assign up_finish = ((state == S_UP_RD) && (n == IW'(1))) ||
                     ((state == S_UP_CMP) && !lt);
  // A delete whose entry did not climb goes on to sift down instead.
  assign up_write_cur = up_finish && (moved || !del_mode);
  assign dn_sel = (r_ok && lt) ? SEL_RIGHT : best_sel;

  // The finished result moves to the output register once that register is free.
  assign fin_take = (state == S_FIN) && (!out_valid || res.ready);

  // Memory read addresses per step.
  always_comb begin
    addr_a = '0;
    addr_b = '0;
    case (state)
      S_SRCH:   addr_a = scan[IW-1:0];
      S_DEL_RD: addr_a = count;
      S_TK_RD, S_TK_CHK: begin
        addr_a = IW'(1);
        addr_b = count;
      end
      S_UP_RD, S_UP_CMP: addr_a = parent;
      S_DN_RD, S_DN_CMP_L, S_DN_CMP_R: begin
        addr_a = child_l[IW-1:0];
        addr_b = child_r[IW-1:0];
      end
      default: begin
        addr_a = '0;
        addr_b = '0;
      end
    endcase
  end

  // Heap memory write: a moved neighbor or the carried entry at its final place.
  always_comb begin
    we    = 1'b0;
    waddr = n;
    wdata = cur;
    case (state)
      S_UP_RD: we = up_write_cur;
      S_UP_CMP: begin
        we    = lt || up_write_cur;
        wdata = lt ? rd_a : cur;
      end
      S_DN_RD: we = !l_ok;
      S_DN_CMP_R: begin
        we = 1'b1;
        case (dn_sel)
          SEL_LEFT:  wdata = rd_a;
          SEL_RIGHT: wdata = rd_b;
          default:   wdata = cur;
        endcase
      end
      default: we = 1'b0;
    endcase
  end

  assign per_we = (state == S_INS) && (count < IW'(MAX_TIMERS));

  always_ff @(posedge clk) begin
    if (we) begin
      heap_mem[waddr] <= wdata;
    end
    if (we && (waddr == IW'(1))) begin
      root_dl <= wdata.dl;
    end
    rd_a <= heap_mem[addr_a];
    rd_b <= heap_mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (per_we) begin
      per_mem[id_q] <= '{rep: rep_q, period: iv_q};
    end
    per_rd <= per_mem[rd_a.id];
  end

  assign count_ext = (IW + 6)'(count);

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      moved     <= 1'b0;
      del_mode  <= 1'b0;
      chk_vld   <= 1'b0;
    end else begin
      // The output register fills with a finished result or empties once taken.
      if (fin_take) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            id_q    <= cmd.timer_id;
            dl_q    <= cmd.deadline;
            iv_q    <= cmd.interval;
            rep_q   <= cmd.repeating;
            now_q   <= cmd.now;
            st_q    <= tmh_pkg::ST_DONE;
            fired_q <= 1'b0;
            fid_q   <= '0;
            scan    <= (IW + 1)'(1);
            chk_vld <= 1'b0;
            case (tmh_pkg::tmh_action_t'(cmd.action))
              tmh_pkg::ACT_INSERT: state <= S_INS;
              tmh_pkg::ACT_DELETE: state <= S_SRCH;
              tmh_pkg::ACT_TICK:   state <= S_TK_RD;
              default:             state <= S_FIN;
            endcase
          end
        end
        S_INS: begin
          if (count >= IW'(MAX_TIMERS)) begin
            st_q  <= tmh_pkg::ST_FULL;
            state <= S_FIN;
          end else begin
            count    <= count + IW'(1);
            n        <= count + IW'(1);
            cur      <= '{id: id_q, dl: dl_q};
            moved    <= 1'b0;
            del_mode <= 1'b0;
            state    <= S_UP_RD;
          end
        end
        // Linear scan: one read issued per cycle, checked in the next cycle.
        S_SRCH: begin
          if (count == '0) begin
            st_q  <= tmh_pkg::ST_NOT_FOUND;
            state <= S_FIN;
          end else if (chk_vld && (rd_a.id == id_q)) begin
            hit   <= chk_pos;
            state <= S_DEL_RD;
          end else if (chk_vld && (chk_pos == count)) begin
            st_q  <= tmh_pkg::ST_NOT_FOUND;
            state <= S_FIN;
          end else begin
            chk_pos <= scan[IW-1:0];
            chk_vld <= 1'b1;
            scan    <= scan + (IW + 1)'(1);
          end
        end
        S_DEL_RD: state <= S_DEL_MV;
        // The last entry fills the hole unless the hole was the last slot.
        S_DEL_MV: begin
          cur   <= rd_a;
          count <= count - IW'(1);
          if (hit == count) begin
            state <= S_FIN;
          end else begin
            n        <= hit;
            moved    <= 1'b0;
            del_mode <= 1'b1;
            state    <= S_UP_RD;
          end
        end
        S_TK_RD: begin
          if (count == '0) begin
            st_q  <= tmh_pkg::ST_NOT_DUE;
            state <= S_FIN;
          end else begin
            state <= S_TK_CHK;
          end
        end
        S_TK_CHK: begin
          if (!due) begin
            st_q  <= tmh_pkg::ST_NOT_DUE;
            state <= S_FIN;
          end else begin
            fired_q <= 1'b1;
            fid_q   <= rd_a.id;
            cur     <= rd_a;
            state   <= S_TK_APPLY;
          end
        end
        // A repeating root moves its deadline on; a one-shot root is replaced by the last.
        S_TK_APPLY: begin
          n <= IW'(1);
          if (per_rd.rep) begin
            cur.dl <= cur.dl + per_rd.period;
            state  <= S_DN_RD;
          end else begin
            cur   <= rd_b;
            count <= count - IW'(1);
            state <= (count == IW'(1)) ? S_FIN : S_DN_RD;
          end
        end
        S_UP_RD: begin
          if (up_finish) begin
            state <= up_write_cur ? S_FIN : S_DN_RD;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (lt) begin
            n     <= parent;
            moved <= 1'b1;
            state <= S_UP_RD;
          end else begin
            state <= up_write_cur ? S_FIN : S_DN_RD;
          end
        end
        S_DN_RD: begin
          state <= l_ok ? S_DN_CMP_L : S_FIN;
        end
        S_DN_CMP_L: begin
          best_dl  <= lt ? rd_a.dl : cur.dl;
          best_sel <= lt ? SEL_LEFT : SEL_SELF;
          state    <= S_DN_CMP_R;
        end
        S_DN_CMP_R: begin
          case (dn_sel)
            SEL_LEFT: begin
              n     <= child_l[IW-1:0];
              state <= S_DN_RD;
            end
            SEL_RIGHT: begin
              n     <= child_r[IW-1:0];
              state <= S_DN_RD;
            end
            default: state <= S_FIN;
          endcase
        end
        // Hand the result over once the output register is free.
        S_FIN: begin
          if (fin_take) begin
            out_status <= st_q;
            out_fired  <= fired_q;
            out_fid    <= fid_q;
            out_count  <= count_ext[5:0];
            out_next   <= (count != '0) ? root_dl : '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready         = (state == S_IDLE);
  assign res.valid         = out_valid;
  assign res.status        = out_status;
  assign res.fired         = out_fired;
  assign res.fired_id      = out_fid;
  assign res.timer_count   = out_count;
  assign res.next_deadline = out_next;

endmodule

FILE: rtl/tmh_checker.sv
// Port-level assertions for the timer heap and the bind that attaches them.
module tmh_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    cmd_valid,
  input logic                    cmd_ready,
  input logic                    res_valid,
  input logic                    res_ready,
  input logic [1:0]              res_status,
  input logic                    res_fired,
  input logic [tmh_pkg::IdW-1:0] res_fired_id,
  input logic [5:0]              res_timer_count,
  input logic [tmh_pkg::DlW-1:0] res_next_deadline
);

  logic [1:0] pend;
  logic       cmd_acc;
  logic       res_acc;

  assign cmd_acc = cmd_valid && cmd_ready;
  assign res_acc = res_valid && res_ready;

  // Words taken in whose results have not yet been taken out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'd0;
    end else begin
      pend <= pend + {1'b0, cmd_acc} - {1'b0, res_acc};
    end
  end

  // A result only ever answers a command already taken in.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pend != 2'd0)
    else $error("result shown with no command outstanding");

  // At most one command in work next to one waiting result.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    cmd_acc |-> pend != 2'd2)
    else $error("command taken while one is in work and one result waits");

  // A fired timer always reports plain completion.
  a_fired_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_fired |-> res_status == tmh_pkg::ST_DONE)
    else $error("fired timer with a status other than done");

  // No id is reported unless a timer fired.
  a_idle_id: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_fired |-> res_fired_id == '0)
    else $error("fired id set on a result that did not fire");

  // A stalled result holds its word.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_status) && $stable(res_fired) &&
      $stable(res_fired_id) && $stable(res_timer_count) && $stable(res_next_deadline))
    else $error("result word changed while stalled");

endmodule

bind timer_min_heap_scheduler tmh_checker u_tmh_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_status        (res.status),
  .res_fired         (res.fired),
  .res_fired_id      (res.fired_id),
  .res_timer_count   (res.timer_count),
  .res_next_deadline (res.next_deadline)
);
